[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("concurrent assertion failed");

// Concurrent assertion on the usual clk_i and rst_ni.
`define ASSERT_STD(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

[rtl/core/tcc_pkg.sv]
package tcc_pkg;

  localparam int unsigned TEXT_COLUMNS = 100;
  localparam int unsigned TEXT_LINES   = 37;
  localparam int unsigned SCREEN_LINES = 600;
  localparam int unsigned CELL_HEIGHT  = 16;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned LINE_W  = 10;
  localparam int unsigned MARK_W  = 12;
  localparam int unsigned COLOR_W = 32;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_UPLOAD = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    K_NONE,
    K_CR,
    K_LF,
    K_BS,
    K_TAB,
    K_CHAR,
    K_CLEAR,
    K_FLUSH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         char_code;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } tcc_cmd_t;

  typedef struct packed {
    action_e            action;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [7:0]         glyph_code;
    logic [COLOR_W-1:0] draw_fg;
    logic [COLOR_W-1:0] draw_bg;
    logic [LINE_W-1:0]  upload_top;
    logic [LINE_W-1:0]  upload_lines;
    logic               last;
  } tcc_result_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic head_valid;
  } tcc_qstat_t;

endpackage

[rtl/core/tcc_in_if.sv]
interface tcc_in_if
  import tcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         char_code;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  modport source (output valid, output opcode, output char_code, output fg_color,
                  output bg_color, input ready);
  modport sink (input valid, input opcode, input char_code, input fg_color,
                input bg_color, output ready);
endinterface

[rtl/core/tcc_out_if.sv]
interface tcc_out_if
  import tcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [COL_W-1:0]   cell_col;
  logic [ROW_W-1:0]   cell_row;
  logic [7:0]         glyph_code;
  logic [COLOR_W-1:0] draw_fg;
  logic [COLOR_W-1:0] draw_bg;
  logic [LINE_W-1:0]  upload_top;
  logic [LINE_W-1:0]  upload_lines;
  logic               last;

  modport source (output valid, output action, output cell_col, output cell_row,
                  output glyph_code, output draw_fg, output draw_bg, output upload_top,
                  output upload_lines, output last, input ready);
  modport sink (input valid, input action, input cell_col, input cell_row,
                input glyph_code, input draw_fg, input draw_bg, input upload_top,
                input upload_lines, input last, output ready);
endinterface

[rtl/core/text_console_cursor_control_core.sv]
// Channel  Dir  Handshake      Payload
// in_i     in   valid / ready  opcode, char_code, fg_color, bg_color
// out_o    out  valid / ready  action, cell position, glyph, colors, upload range, last
//
// One command beat is taken per cycle while the two-entry queue has room; it is written
// into the queue, and once it is at the queue head its result beat is loaded into the
// output register. A printable character that wraps into a scroll gives two beats and
// holds the head until both are loaded. Commands without a result retire even while the
// output is stalled; the others wait for the output register to free. Reset empties the
// queue and the output register, homes the cursor and leaves the dirty range empty.
module text_console_cursor_control_core
  import tcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);

  tcc_qstat_t qstat;
  tcc_cmd_t   push_cmd;
  tcc_cmd_t   head_cmd;
  logic       push;
  logic       pop;

  // The front end decodes each beat into a command kind and pushes it.
  tcc_front u_front (
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // The queue lets the input keep streaming while the output is stalled.
  tcc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .qstat_o    (qstat),
    .head_o     (head_cmd)
  );

  // The back end owns the cursor and the dirty range and issues the result beats.
  tcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .head_i  (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[rtl/core/tcc_front.sv]
module tcc_front
  import tcc_pkg::*;
(
  tcc_in_if.sink     in_i,
  input  tcc_qstat_t qstat_i,
  output logic       push_o,
  output tcc_cmd_t   cmd_o
);

  // Decode the opcode and the control characters into one command kind.
  always_comb begin
    cmd_o.char_code = in_i.char_code;
    cmd_o.fg_color  = in_i.fg_color;
    cmd_o.bg_color  = in_i.bg_color;
    unique case (in_i.opcode)
      OP_PUT: begin
        case (in_i.char_code)
          CH_CR:   cmd_o.kind = K_CR;
          CH_LF:   cmd_o.kind = K_LF;
          CH_BS:   cmd_o.kind = K_BS;
          CH_TAB:  cmd_o.kind = K_TAB;
          default: cmd_o.kind = K_CHAR;
        endcase
      end
      OP_CLEAR: cmd_o.kind = K_CLEAR;
      OP_FLUSH: cmd_o.kind = K_FLUSH;
      default:  cmd_o.kind = K_NONE;
    endcase
  end

  assign in_i.ready = !qstat_i.full;
  assign push_o     = in_i.valid && !qstat_i.full;

endmodule

[rtl/core/tcc_queue.sv]
module tcc_queue
  import tcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tcc_cmd_t   push_cmd_i,
  input  logic       pop_i,
  output tcc_qstat_t qstat_o,
  output tcc_cmd_t   head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tcc_cmd_t           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign qstat_o.full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign qstat_o.head_valid = (count_q != '0);
  assign head_o             = entry_q[rd_ptr_q];

  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && qstat_o.head_valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/tcc_back.sv]
module tcc_back
  import tcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tcc_qstat_t qstat_i,
  input  tcc_cmd_t   head_i,
  output logic       pop_o,
  tcc_out_if.source  out_o
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [LINE_W-1:0] dtop_q, dtop_d;
  logic [LINE_W-1:0] dend_q, dend_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  tcc_result_t       res_q, res_d;

  logic              slot_free, load, go, need_out, two_res;
  logic              mark_draw, mark_full, flush_clear;
  logic [ROW_W:0]    row_inc;
  logic              nr_scroll;
  logic [ROW_W-1:0]  nr_row;
  logic [COL_W:0]    tab_col, chr_col;
  logic [MARK_W-1:0] mark_y, mark_e;
  logic [LINE_W-1:0] draw_top, draw_end;
  logic [COL_W-1:0]  ncol;
  logic [ROW_W-1:0]  nrow;
  tcc_result_t       res;

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    row_inc   = {1'b0, row_q} + (ROW_W + 1)'(1);
    nr_scroll = (row_inc >= (ROW_W + 1)'(TEXT_LINES));
    nr_row    = nr_scroll ? ROW_W'(TEXT_LINES - 1) : row_inc[ROW_W-1:0];
    tab_col   = ({1'b0, col_q} + (COL_W + 1)'(4)) & ~(COL_W + 1)'(3);
    chr_col   = {1'b0, col_q} + (COL_W + 1)'(1);
    mark_y    = MARK_W'(row_q) * MARK_W'(CELL_HEIGHT);
    mark_e    = mark_y + MARK_W'(CELL_HEIGHT);
    draw_top  = (mark_y > MARK_W'(SCREEN_LINES)) ? LINE_W'(SCREEN_LINES)
                                                 : mark_y[LINE_W-1:0];
    draw_end  = (mark_e > MARK_W'(SCREEN_LINES)) ? LINE_W'(SCREEN_LINES)
                                                 : mark_e[LINE_W-1:0];

    // Candidate effect of the head command.
    ncol        = col_q;
    nrow        = row_q;
    need_out    = 1'b0;
    two_res     = 1'b0;
    mark_draw   = 1'b0;
    mark_full   = 1'b0;
    flush_clear = 1'b0;
    res         = '0;
    res.last    = 1'b1;
    case (head_i.kind)
      K_CR: ncol = '0;
      K_LF: begin
        ncol      = '0;
        nrow      = nr_row;
        need_out  = nr_scroll;
        mark_full = nr_scroll;
        res.action = ACT_SCROLL;
      end
      K_BS: begin
        if (col_q != '0) begin
          ncol           = col_q - COL_W'(1);
          need_out       = 1'b1;
          mark_draw      = 1'b1;
          res.action     = ACT_DRAW;
          res.cell_col   = col_q - COL_W'(1);
          res.cell_row   = row_q;
          res.glyph_code = CH_SPACE;
          res.draw_fg    = head_i.fg_color;
          res.draw_bg    = head_i.bg_color;
        end
      end
      K_TAB: begin
        res.action = ACT_SCROLL;
        if (tab_col >= (COL_W + 1)'(TEXT_COLUMNS)) begin
          ncol      = '0;
          nrow      = nr_row;
          need_out  = nr_scroll;
          mark_full = nr_scroll;
        end else begin
          ncol = tab_col[COL_W-1:0];
        end
      end
      K_CHAR: begin
        need_out       = 1'b1;
        mark_draw      = 1'b1;
        res.action     = ACT_DRAW;
        res.cell_col   = col_q;
        res.cell_row   = row_q;
        res.glyph_code = head_i.char_code;
        res.draw_fg    = head_i.fg_color;
        res.draw_bg    = head_i.bg_color;
        if (chr_col >= (COL_W + 1)'(TEXT_COLUMNS)) begin
          ncol      = '0;
          nrow      = nr_row;
          two_res   = nr_scroll;
          mark_full = nr_scroll;
          res.last  = !nr_scroll;
        end else begin
          ncol = chr_col[COL_W-1:0];
        end
      end
      K_CLEAR: begin
        ncol       = '0;
        nrow       = '0;
        need_out   = 1'b1;
        mark_full  = 1'b1;
        res.action = ACT_CLEAR;
      end
      K_FLUSH: begin
        if (dend_q > dtop_q) begin
          need_out         = 1'b1;
          flush_clear      = 1'b1;
          res.action       = ACT_UPLOAD;
          res.upload_top   = dtop_q;
          res.upload_lines = dend_q - dtop_q;
        end
      end
      default: ;
    endcase

    col_d  = col_q;
    row_d  = row_q;
    dtop_d = dtop_q;
    dend_d = dend_q;
    pend_d = pend_q;
    pop_o  = 1'b0;
    load   = 1'b0;
    go     = 1'b0;
    res_d  = res;

    if (pend_q) begin
      // Second beat of a wrapping character: the scroll, state already updated.
      res_d        = '0;
      res_d.action = ACT_SCROLL;
      res_d.last   = 1'b1;
      if (slot_free) begin
        load   = 1'b1;
        pop_o  = 1'b1;
        pend_d = 1'b0;
      end
    end else if (qstat_i.head_valid) begin
      go = !need_out || slot_free;
      if (go) begin
        col_d  = ncol;
        row_d  = nrow;
        load   = need_out;
        pend_d = two_res;
        pop_o  = !two_res;
        if (flush_clear) begin
          dtop_d = LINE_W'(SCREEN_LINES);
          dend_d = '0;
        end else if (mark_full) begin
          dtop_d = '0;
          dend_d = LINE_W'(SCREEN_LINES);
        end else if (mark_draw) begin
          dtop_d = (draw_top < dtop_q) ? draw_top : dtop_q;
          dend_d = (draw_end > dend_q) ? draw_end : dend_q;
        end
      end
    end

    out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      dtop_q      <= LINE_W'(SCREEN_LINES);
      dend_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      dtop_q      <= dtop_d;
      dend_q      <= dend_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.action       = res_q.action;
  assign out_o.cell_col     = res_q.cell_col;
  assign out_o.cell_row     = res_q.cell_row;
  assign out_o.glyph_code   = res_q.glyph_code;
  assign out_o.draw_fg      = res_q.draw_fg;
  assign out_o.draw_bg      = res_q.draw_bg;
  assign out_o.upload_top   = res_q.upload_top;
  assign out_o.upload_lines = res_q.upload_lines;
  assign out_o.last         = res_q.last;

endmodule

[rtl/core/tcc_checker.sv]
`include "assert_macros.svh"

module tcc_checker
  import tcc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         action_i,
  input logic [COL_W-1:0]   cell_col_i,
  input logic [ROW_W-1:0]   cell_row_i,
  input logic [7:0]         glyph_code_i,
  input logic [COLOR_W-1:0] draw_fg_i,
  input logic [COLOR_W-1:0] draw_bg_i,
  input logic [LINE_W-1:0]  upload_top_i,
  input logic [LINE_W-1:0]  upload_lines_i,
  input logic               last_i
);

  logic [LINE_W:0] upload_end;
  logic            out_stall;
  logic            out_fire;
  logic            upload_ok;
  logic            cell_clean;

  assign upload_end = (LINE_W + 1)'(upload_top_i) + (LINE_W + 1)'(upload_lines_i);
  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_fire   = out_valid_i && out_ready_i;
  assign upload_ok  = upload_lines_i != '0 && upload_end <= (LINE_W + 1)'(SCREEN_LINES);
  assign cell_clean = cell_col_i == '0 && cell_row_i == '0 && glyph_code_i == '0 &&
                      draw_fg_i == '0 && draw_bg_i == '0;

  `ASSERT_STD(a_stall_hold, out_stall |=> out_valid_i && $stable(action_i) && $stable(last_i))

  `ASSERT_STD(a_nondraw_last, out_valid_i && action_i != ACT_DRAW |-> last_i)

  `ASSERT_STD(a_wrap_scroll, out_fire && !last_i |=> out_valid_i && action_i == ACT_SCROLL)

  `ASSERT_STD(a_upload_range, out_valid_i && action_i == ACT_UPLOAD |-> upload_ok)

  `ASSERT_STD(a_nondraw_clean, out_valid_i && action_i != ACT_DRAW |-> cell_clean)

endmodule

bind text_console_cursor_control_core tcc_checker u_tcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .action_i       (out_o.action),
  .cell_col_i     (out_o.cell_col),
  .cell_row_i     (out_o.cell_row),
  .glyph_code_i   (out_o.glyph_code),
  .draw_fg_i      (out_o.draw_fg),
  .draw_bg_i      (out_o.draw_bg),
  .upload_top_i   (out_o.upload_top),
  .upload_lines_i (out_o.upload_lines),
  .last_i         (out_o.last)
);
